// ===== design/b64c_pkg.sv =====
// Shared types, constants and lookup functions for the base64 codec.
// No dependencies; imported by every design module of the codec.
package b64c_pkg;

	// Direction register codes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// Pad character '='
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Kind of work handed from front to back
	typedef enum logic {
		JOB_BYTE,   // one result: decoded byte or empty end marker
		JOB_GROUP   // four encoded characters from a 24-bit group
	} b64c_kind_t;

	typedef struct packed {
		b64c_kind_t  kind;
		logic [23:0] data;     // group bits, or byte in [7:0]
		logic [1:0]  count;    // bytes held in the group, 1..3
		logic        present;  // byte result holds data
		logic        last;     // final result of the string
	} b64c_job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} b64c_sextet_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] b64c_char(input logic [5:0] v);
		logic [7:0] v8;
		v8 = {2'b00, v};
		if (v8 < 8'd26)
			return 8'h41 + v8;
		else if (v8 < 8'd52)
			return 8'h61 + v8 - 8'd26;
		else if (v8 < 8'd62)
			return 8'h30 + v8 - 8'd52;
		else if (v8 == 8'd62)
			return 8'h2B;
		else
			return 8'h2F;
	endfunction

	// Alphabet character to 6-bit value; ok is low outside the alphabet
	function automatic b64c_sextet_t b64c_sextet(input logic [7:0] c);
		b64c_sextet_t r;
		logic [7:0]   t;
		r = '0;
		t = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
			r.ok = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'h61 + 8'd26;
			r.ok = 1'b1;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30 + 8'd52;
			r.ok = 1'b1;
		end else if (c == 8'h2B) begin
			t = 8'd62;
			r.ok = 1'b1;
		end else if (c == 8'h2F) begin
			t = 8'd63;
			r.ok = 1'b1;
		end
		r.value = t[5:0];
		return r;
	endfunction

endpackage

// ===== design/base64_codec_unit.sv =====
// A request accepted by the front is written into the job queue and then
// into the output register before its first result shows on the outputs.
// Throughput: one request per cycle while in_stall is low; the output reg
// moves one result per cycle unless stalled, four results per encode group.
// Reset (arst_n low, asynchronous): encode mode, string state and queue clear.
module base64_codec_unit
	import b64c_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       out_last
);

	logic      push;
	logic      pop;
	logic      full;
	logic      not_empty;
	b64c_job_t wr_job;
	b64c_job_t head;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	b64c_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (full),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.push          (push),
		.job           (wr_job)
	);

	b64c_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	b64c_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (not_empty),
		.job          (head),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.out_last     (out_last)
	);

endmodule

// ===== design/b64c_front.sv =====
// Front end of the base64 codec: holds the direction register and the
// per-string state, classifies each request and pushes jobs. Uses b64c_pkg.
module b64c_front
	import b64c_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	input  logic      cfg_data,
	input  logic      in_valid,
	input  logic      in_stall,
	input  logic [7:0] data_byte,
	input  logic      end_of_string,
	output logic      push,
	output b64c_job_t job
);

	logic        mode_q;
	logic [23:0] acc_q;
	logic [1:0]  pcnt_q;   // bytes held in the encode group
	logic [2:0]  pbits_q;  // decode bits ready, less than eight
	logic        stop_q;

	logic         accept;
	logic [23:0]  acc_d;
	logic [1:0]   pcnt_d;
	logic [2:0]   pbits_d;
	logic         stop_d;
	logic [23:0]  enc_acc;
	logic [1:0]   enc_cnt;
	logic [3:0]   bits;
	logic [3:0]   shift;
	logic [11:0]  acc12;
	logic [11:0]  shifted;
	b64c_sextet_t sx;

	assign accept = in_valid && !in_stall;

	// Classify the request and compute next string state
	always_comb begin
		acc_d   = acc_q;
		pcnt_d  = pcnt_q;
		pbits_d = pbits_q;
		stop_d  = stop_q;
		push    = 1'b0;
		job     = '0;
		enc_acc = acc_q;
		enc_cnt = pcnt_q + 2'd1;
		bits    = {1'b0, pbits_q} + 4'd6;
		shift   = bits - 4'd8;
		acc12   = {acc_q[5:0], 6'b0};
		shifted = 12'h000;
		sx      = b64c_sextet(data_byte);

		if (mode_q == MODE_ENCODE) begin
			// drop the byte into its slot of the group
			case (pcnt_q)
				2'd0:    enc_acc[23:16] = data_byte;
				2'd1:    enc_acc[15:8]  = data_byte;
				2'd2:    enc_acc[7:0]   = data_byte;
				default: enc_acc        = acc_q;
			endcase
			if (enc_cnt == 2'd3 || end_of_string) begin
				push        = accept;
				job.kind    = JOB_GROUP;
				job.data    = enc_acc;
				job.count   = enc_cnt;
				job.present = 1'b1;
				job.last    = end_of_string;
				acc_d       = '0;
				pcnt_d      = 2'd0;
			end else begin
				acc_d  = enc_acc;
				pcnt_d = enc_cnt;
			end
		end else begin
			// decode: six bits per character, a byte once eight are ready
			job.kind = JOB_BYTE;
			if (!stop_q) begin
				if (!sx.ok) begin
					stop_d = 1'b1;
				end else begin
					acc12 = {acc_q[5:0], sx.value};
					acc_d = {12'h000, acc12};
					if (bits >= 4'd8) begin
						shifted     = acc12 >> shift;
						push        = accept;
						job.data    = {16'h0000, shifted[7:0]};
						job.present = 1'b1;
						job.last    = end_of_string;
						pbits_d     = shift[2:0];
					end else begin
						pbits_d = bits[2:0];
					end
				end
			end
			// end of string with no byte: empty end marker
			if (end_of_string && !push) begin
				push        = accept;
				job.data    = '0;
				job.present = 1'b0;
				job.last    = 1'b1;
			end
		end

		if (end_of_string) begin
			acc_d   = '0;
			pcnt_d  = 2'd0;
			pbits_d = 3'd0;
			stop_d  = 1'b0;
		end
	end

	// Direction register and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENCODE;
			acc_q   <= '0;
			pcnt_q  <= 2'd0;
			pbits_q <= 3'd0;
			stop_q  <= 1'b0;
		end else if (cfg_valid) begin
			mode_q  <= cfg_data;
			acc_q   <= '0;
			pcnt_q  <= 2'd0;
			pbits_q <= 3'd0;
			stop_q  <= 1'b0;
		end else if (accept) begin
			acc_q   <= acc_d;
			pcnt_q  <= pcnt_d;
			pbits_q <= pbits_d;
			stop_q  <= stop_d;
		end
	end

endmodule

// ===== design/b64c_queue.sv =====
// Short job queue between the codec front and back ends.
// Register-based FIFO of b64c_job_t entries; uses b64c_pkg.
module b64c_queue
	import b64c_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  b64c_job_t wr_job,
	input  logic      pop,
	output logic      full,
	output logic      not_empty,
	output b64c_job_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64c_job_t        mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("job queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("job queue fill count out of range");
`endif

endmodule

// ===== design/b64c_back.sv =====
// Back end of the base64 codec: expands queued jobs into results, one per
// cycle while out_stall is low, into a stallable output register. Uses b64c_pkg.
module b64c_back
	import b64c_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  b64c_job_t  job,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       out_last
);

	localparam logic [1:0] LAST_IDX = 2'd3;

	logic [1:0] idx_q;     // character position within a group
	logic       valid_q;
	logic [7:0] byte_q;
	logic       present_q;
	logic       last_q;

	logic       adv;
	logic [5:0] sext;
	logic       pad;
	logic [7:0] res_byte;
	logic       res_last;

	assign adv = !valid_q || !out_stall;
	assign pop = adv && job_valid && (job.kind == JOB_BYTE || idx_q == LAST_IDX);

	// Result for the current position of the head job
	always_comb begin
		case (idx_q)
			2'd0:    sext = job.data[23:18];
			2'd1:    sext = job.data[17:12];
			2'd2:    sext = job.data[11:6];
			default: sext = job.data[5:0];
		endcase
		pad = (idx_q == 2'd2 && job.count == 2'd1) ||
		      (idx_q == LAST_IDX && job.count != 2'd3);
		if (job.kind == JOB_GROUP) begin
			res_byte = pad ? PAD_CHAR : b64c_char(sext);
			res_last = (idx_q == LAST_IDX) && job.last;
		end else begin
			res_byte = job.data[7:0];
			res_last = job.last;
		end
	end

	// Position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= job_valid;
			if (job_valid)
				idx_q <= pop ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (adv && job_valid) begin
			byte_q    <= res_byte;
			present_q <= (job.kind == JOB_GROUP) || job.present;
			last_q    <= res_last;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign byte_present = present_q;
	assign out_last     = last_q;

`ifndef SYNTHESIS
	a_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> job_valid && job.kind == JOB_GROUP)
		else $error("group position advanced without a group job at the head");
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !present_q |-> last_q)
		else $error("empty result not marked last");
`endif

endmodule

// ===== verif/base64_codec_unit_test.sv =====
// Self-checking bench for base64_codec_unit: encode and decode strings, mode writes, stalls.
// Needs b64c_pkg and the four design modules; a built-in predictor gives the expected results.
// Requests come from a step queue filled at time zero, sent by a clocked driver.
module base64_codec_unit_test
	import b64c_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Quiet cycles required before a mode write or the end of a drain
	localparam int IDLE_SETTLE = 6;
	localparam int END_LIMIT   = 20000;
	localparam int PHASE_ITEMS = 56;

	typedef enum logic [1:0] {
		STEP_BYTE,   // one input request
		STEP_MODE,   // direction register write
		STEP_DRAIN,  // hold off until all results are in
		STEP_PHASE   // new idle and stall rates
	} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [7:0] data;
		logic       eos;
		logic [6:0] send_pct;
		logic [6:0] recv_pct;
	} codec_step_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       present;
		logic       last;
	} codec_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       byte_present;
	logic       out_last;

	codec_step_t   pending_steps[$];
	codec_result_t codec_results_due[$];

	// Predictor state
	logic        codec_mode = MODE_ENCODE;
	logic [23:0] group_bits = '0;
	logic [1:0]  group_count = '0;
	logic [3:0]  bits_ready = '0;   // bits ready, less than eight
	logic        decode_halted = 1'b0;

	logic stim_mode = MODE_ENCODE;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   quiet_cycles = 0;
	int   mismatch_count = 0;
	int   results_seen = 0;

	base64_codec_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.out_last     (out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Alphabet lookups
	function automatic logic [7:0] char_of_sextet(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (w < 8'd26)
			return "A" + w;
		if (w < 8'd52)
			return "a" + (w - 8'd26);
		if (w < 8'd62)
			return "0" + (w - 8'd52);
		if (w == 8'd62)
			return "+";
		return "/";
	endfunction

	function automatic int sextet_of_char(input logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return int'(c - "A");
		if (c >= "a" && c <= "z")
			return int'(c - "a") + 26;
		if (c >= "0" && c <= "9")
			return int'(c - "0") + 52;
		if (c == "+")
			return 62;
		if (c == "/")
			return 63;
		return -1;
	endfunction

	task automatic queue_result(input logic [7:0] ch, input logic present, input logic last);
		codec_result_t r;
		r.ch = ch;
		r.present = present;
		r.last = last;
		codec_results_due = {codec_results_due, r};
	endtask

	task automatic clear_string_state();
		group_bits = '0;
		group_count = '0;
		bits_ready = '0;
		decode_halted = 1'b0;
	endtask

	// Expected results of one accepted request
	task automatic predict_codec_step(input logic [7:0] b, input logic eos);
		logic [1:0] held;
		logic [4:0] bits;
		int         v;
		bit         emitted;
		emitted = 1'b0;
		if (codec_mode == MODE_ENCODE) begin
			held = group_count;
			group_bits = group_bits | (24'(b) << (16 - 8 * held));
			held = held + 2'd1;
			if (held == 2'd3 || eos) begin
				queue_result(char_of_sextet(group_bits[23:18]), 1'b1, 1'b0);
				queue_result(char_of_sextet(group_bits[17:12]), 1'b1, 1'b0);
				queue_result(held >= 2'd2 ? char_of_sextet(group_bits[11:6]) : PAD_CHAR,
					1'b1, 1'b0);
				queue_result(held == 2'd3 ? char_of_sextet(group_bits[5:0]) : PAD_CHAR,
					1'b1, eos);
				group_bits = '0;
				group_count = '0;
			end else begin
				group_count = held;
			end
		end else begin
			if (!decode_halted) begin
				v = sextet_of_char(b);
				if (v < 0) begin
					decode_halted = 1'b1;
				end else begin
					bits = {1'b0, bits_ready} + 5'd6;
					group_bits = ((group_bits << 6) | 24'(v)) & 24'hFFF;
					if (bits >= 5'd8) begin
						bits = bits - 5'd8;
						queue_result(8'(group_bits >> bits), 1'b1, eos);
						emitted = 1'b1;
					end
					bits_ready = bits[3:0];
				end
			end
			// nothing produced on the last character: empty end marker
			if (eos && !emitted)
				queue_result(8'h00, 1'b0, 1'b1);
		end
		if (eos)
			clear_string_state();
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t: %s wrong at result %0d: got %0h, want %0h",
				$time, what, results_seen, got, want);
	endtask

	task automatic queue_step(input step_kind_t kind, input logic [7:0] data,
		input logic eos, input int send_pct, input int recv_pct);
		codec_step_t s;
		s.kind = kind;
		s.data = data;
		s.eos = eos;
		s.send_pct = 7'(send_pct);
		s.recv_pct = 7'(recv_pct);
		if (kind == STEP_MODE)
			stim_mode = data[0];
		pending_steps = {pending_steps, s};
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_step(STEP_BYTE, s[i], i == s.len() - 1, 0, 0);
	endtask

	// Request driver: predicts on acceptance, then presents the next step
	always @(posedge clk) begin : request_driver
		codec_step_t head;
		logic        hold_req;
		logic        hold_cfg;
		if (arst_n) begin
			hold_req = in_valid;
			hold_cfg = cfg_valid;
			if (in_valid && !in_stall) begin
				predict_codec_step(data_byte, end_of_string);
				hold_req = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				codec_mode = cfg_data;
				clear_string_state();
				hold_cfg = 1'b0;
			end
			if (codec_results_due.size() == 0 && !in_valid && !cfg_valid && !out_valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;

			if (!hold_req && !hold_cfg && pending_steps.size() != 0) begin
				head = pending_steps[0];
				case (head.kind)
					STEP_BYTE: begin
						if ($urandom_range(99) >= send_idle_pct) begin
							hold_req = 1'b1;
							data_byte <= head.data;
							end_of_string <= head.eos;
							void'(pending_steps.pop_front());
						end
					end
					STEP_MODE: begin
						// mode writes only once the block has gone quiet
						if (quiet_cycles >= IDLE_SETTLE) begin
							hold_cfg = 1'b1;
							cfg_data <= head.data[0];
							void'(pending_steps.pop_front());
						end
					end
					STEP_DRAIN: begin
						if (quiet_cycles >= IDLE_SETTLE)
							void'(pending_steps.pop_front());
					end
					default: begin
						send_idle_pct = head.send_pct;
						recv_stall_pct = head.recv_pct;
						void'(pending_steps.pop_front());
					end
				endcase
			end
			in_valid <= hold_req;
			cfg_valid <= hold_cfg;
		end
	end

	// Result monitor: field-by-field check against the oldest expectation
	always @(posedge clk) begin : result_monitor
		codec_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (codec_results_due.size() == 0) begin
					report_mismatch("unexpected result", out_byte, 8'h00);
				end else begin
					want = codec_results_due.pop_front();
					if (out_byte !== want.ch)
						report_mismatch("out_byte", out_byte, want.ch);
					if (byte_present !== want.present)
						report_mismatch("byte_present", 8'(byte_present), 8'(want.present));
					if (out_last !== want.last)
						report_mismatch("out_last", 8'(out_last), 8'(want.last));
				end
				results_seen++;
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin : stimulus
		logic [7:0] text[$];
		int         phase_items;
		int         len;
		int         kind;
		int         pad;
		logic       drop;

		// Encode: one, two and three byte strings, extreme bytes, group then flush
		queue_step(STEP_MODE, 8'(MODE_ENCODE), 1'b0, 0, 0);
		queue_text("M");
		queue_text("Ma");
		queue_text("Man");
		queue_step(STEP_BYTE, 8'hFB, 1'b0, 0, 0);
		queue_step(STEP_BYTE, 8'hEF, 1'b0, 0, 0);
		queue_step(STEP_BYTE, 8'hFF, 1'b0, 0, 0);
		queue_step(STEP_BYTE, 8'h00, 1'b1, 0, 0);
		// partial group dropped by the mode write
		queue_step(STEP_BYTE, 8'h55, 1'b0, 0, 0);
		queue_step(STEP_MODE, 8'(MODE_DECODE), 1'b0, 0, 0);
		// Decode: dropped partial string, full group, padding, top of alphabet
		queue_text("T");
		queue_step(STEP_MODE, 8'(MODE_DECODE), 1'b0, 0, 0);
		queue_text("TWFu");
		queue_text("TQ==");
		queue_text("+/9z");
		// invalid character halts decode, end gives the empty marker
		queue_step(STEP_BYTE, 8'hFF, 1'b0, 0, 0);
		queue_text("A");
		queue_step(STEP_DRAIN, 8'h00, 1'b0, 0, 0);

		// Random strings over four idle and stall phases, each closed by a drain
		for (int p = 0; p < 4; p++) begin
			queue_step(STEP_PHASE, 8'h00, 1'b0, (p == 1) ? 54 : (p == 3) ? 20 : 0,
				(p == 2) ? 54 : (p == 3) ? 20 : 0);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				text.delete();
				if (stim_mode == MODE_ENCODE) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(13, 8) : $urandom_range(7, 1);
					repeat (len)
						text = {text, 8'($urandom_range(255))};
				end else begin
					kind = $urandom_range(9);
					if (kind == 8) begin
						// noise
						len = $urandom_range(6, 1);
						repeat (len)
							text = {text, 8'($urandom_range(255))};
					end else begin
						len = 4 * $urandom_range(3, 1);
						repeat (len)
							text = {text, char_of_sextet(6'($urandom_range(63)))};
						if (kind == 9) begin
							// truncated, no padding
							repeat ($urandom_range(3, 1))
								void'(text.pop_back());
						end else begin
							pad = $urandom_range(2);
							for (int i = 0; i < pad; i++)
								text[len - 1 - i] = PAD_CHAR;
							// broken: one character replaced by any byte
							if (kind >= 6)
								text[$urandom_range(len - 1)] = 8'($urandom_range(255));
						end
					end
				end
				drop = ($urandom_range(11) == 0);
				for (int i = 0; i < text.size(); i++)
					queue_step(STEP_BYTE, text[i], !drop && i == text.size() - 1, 0, 0);
				phase_items += text.size();
				if (drop || $urandom_range(3) == 0)
					queue_step(STEP_MODE, 8'($urandom_range(1)), 1'b0, 0, 0);
			end
			queue_step(STEP_DRAIN, 8'h00, 1'b0, 0, 0);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_steps.size() != 0 || in_valid || cfg_valid)
			@(posedge clk);
		for (int k = 0; k < END_LIMIT && codec_results_due.size() != 0; k++)
			@(posedge clk);
		repeat (4 * IDLE_SETTLE) @(posedge clk);
		if (codec_results_due.size() != 0)
			report_mismatch("missing results", 8'(codec_results_due.size()), 8'h00);

		if (mismatch_count == 0) begin
			$display("base64_codec_unit_test passed");
		end else begin
			$display("base64_codec_unit_test failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("base64_codec_unit_test failed");
		$finish;
	end

endmodule
